[design/vwbs_pkg.sv]
// Shared types and constants for the variable-width bit stack.
package vwbs_pkg;
    localparam int STORE_WORDS = 64;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int CAP_BITS    = STORE_WORDS * WORD_BITS;
    localparam int FILL_W      = $clog2(CAP_BITS + 1);
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {OP_PUSH = 2'd0, OP_PEEK = 2'd1, OP_POP = 2'd2, OP_NOP = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2} status_t;
    typedef enum logic [2:0] {BK_IDLE, BK_RD0, BK_RD1, BK_EX, BK_WR} bk_state_t;

    // Classified command handed from front to back.
    typedef struct packed {
        op_t               op;
        logic [31:0]       value;
        logic [5:0]        count;
    } cmd_t;
endpackage

[design/vwbs_front.sv]
// Front end: saturates count and queues commands for the back end.
module vwbs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  logic [1:0]        op,
    input  logic [31:0]       value,
    input  logic [5:0]        count,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output vwbs_pkg::cmd_t    cmd
);
    import vwbs_pkg::*;

    cmd_t       q_reg [QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       c_in;
    logic       push, pop;

    always_comb
    begin
        c_in.op    = op_t'(op);
        c_in.value = value;
        c_in.count = (count > 6'd32) ? 6'd32 : count;
        stall      = (cnt_reg == 2'(QDEPTH));
        push       = valid && !stall;
        cmd_valid  = (cnt_reg != 2'd0);
        pop        = cmd_valid && cmd_take;
        cmd        = q_reg[rp_reg];
        wp_next    = push ? ~wp_reg : wp_reg;
        rp_next    = pop ? ~rp_reg : rp_reg;
        cnt_next   = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= c_in;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("queue count");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> c_in.count <= 6'd32) else $error("count not saturated");
endmodule

[design/vwbs_back.sv]
// Back end: executes commands against the word memory, holds the result register.
module vwbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  vwbs_pkg::cmd_t    cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       top_bits,
    output logic [11:0]       bit_total,
    output logic [1:0]        status
);
    import vwbs_pkg::*;

    logic [31:0]        mem [STORE_WORDS];
    logic [31:0]        rd_q;
    bk_state_t          st_reg, st_next;
    cmd_t               c_reg;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [31:0]        lo_reg;
    logic               ov_reg;
    logic [31:0]        top_reg;
    logic [11:0]        tot_reg;
    logic [1:0]         sts_reg;
    logic               ov_next;

    logic               mem_en, mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [31:0]        mem_wd;

    // Derived from the latched command
    logic [FILL_W-1:0]  cnt_f, base, endp;
    logic [ADDR_W-1:0]  w_lo, w_hi;
    logic [4:0]         off;
    logic               two;
    logic [63:0]        pair, rev_window, shifted, mask, merged;
    logic [31:0]        pushed, peek_raw, peek_rev;
    logic               fail, start, finish, wr_push;
    logic [FILL_W:0]    room;

    function automatic logic [31:0] rev32(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
            r[i] = x[31-i];
        return r;
    endfunction

    always_comb
    begin
        cnt_f  = FILL_W'(c_reg.count);
        // base = lowest bit position touched
        base   = (c_reg.op == OP_PUSH) ? fill_reg : fill_reg - cnt_f;
        endp   = base + cnt_f - FILL_W'(1);
        w_lo   = base[FILL_W-1:5] < FILL_W'(STORE_WORDS) ? ADDR_W'(base >> 5) : '0;
        w_hi   = ADDR_W'(endp >> 5);
        off    = base[4:0];
        two    = (cnt_f != '0) && (endp[FILL_W-1:5] != base[FILL_W-1:5]);
        room   = (FILL_W+1)'(CAP_BITS) - (FILL_W+1)'(fill_reg);
        if (c_reg.op == OP_PUSH)
            fail = (FILL_W+1)'(cnt_f) > room;
        else if (c_reg.op == OP_PEEK || c_reg.op == OP_POP)
            fail = cnt_f > fill_reg;
        else
            fail = 1'b0;
        pair     = {two ? rd_q : 32'd0, lo_reg};
        peek_raw = 32'(pair >> off);
        // bits oldest at bit 0; newest at count-1 -> reverse into newest at bit 0
        peek_rev = rev32(peek_raw) >> (6'd32 - c_reg.count);
        if (c_reg.count == 6'd0)
            peek_rev = 32'd0;
        // push: value bit0 newest -> at position base+count-1
        pushed   = rev32(c_reg.value) >> (6'd32 - c_reg.count);
        if (c_reg.count == 6'd0)
            pushed = 32'd0;
        mask     = (c_reg.count == 6'd32) ? 64'hFFFF_FFFF : ((64'd1 << c_reg.count) - 64'd1);
        mask     = mask << off;
        shifted  = {32'd0, pushed} << off;
        rev_window = pair;
        merged   = (rev_window & ~mask) | (shifted & mask);
    end

    assign start     = (st_reg == BK_IDLE) && cmd_valid && !(out_valid && out_stall);
    assign cmd_take  = start;
    assign out_valid = ov_reg;
    assign wr_push   = (c_reg.op == OP_PUSH) && !fail && (cnt_f != '0);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE: if (start) st_next = BK_RD0;
            BK_RD0:  st_next = BK_RD1;
            BK_RD1:  st_next = BK_EX;
            BK_EX:   st_next = (wr_push && two) ? BK_WR : BK_IDLE;
            BK_WR:   st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    assign finish = ((st_reg == BK_EX) && !(wr_push && two)) || (st_reg == BK_WR);

    always_comb
    begin
        mem_en   = 1'b0;
        mem_we   = 1'b0;
        mem_addr = w_lo;
        mem_wd   = merged[31:0];
        case (st_reg)
            BK_RD0:
            begin
                mem_en   = 1'b1;
                mem_addr = w_lo;
            end
            BK_RD1:
            begin
                mem_en   = 1'b1;
                mem_addr = w_hi;
            end
            BK_EX:
            begin
                mem_en   = wr_push;
                mem_we   = wr_push;
                mem_addr = w_lo;
            end
            BK_WR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = w_hi;
                mem_wd   = merged[63:32];
            end
            default: mem_en = 1'b0;
        endcase
    end

    // Bit count and result update on the last cycle of a transaction.
    always_comb
    begin
        fill_next = fill_reg;
        ov_next   = ov_reg;
        if (out_valid && !out_stall)
            ov_next = 1'b0;
        if (finish)
        begin
            ov_next = 1'b1;
            if (!fail && c_reg.op == OP_PUSH)
                fill_next = fill_reg + cnt_f;
            else if (!fail && c_reg.op == OP_POP)
                fill_next = fill_reg - cnt_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            fill_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            fill_reg <= fill_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            c_reg <= cmd;
        if (st_reg == BK_RD1)
            lo_reg <= rd_q;
        if (finish)
        begin
            tot_reg <= 12'(fill_next);
            sts_reg <= fail ? ((c_reg.op == OP_PUSH) ? ST_OVER : ST_UNDER) : ST_OK;
            top_reg <= (c_reg.op == OP_PEEK && !fail) ? peek_rev : 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            if (mem_we)
                mem[mem_addr] <= mem_wd;
            else
                rd_q <= mem[mem_addr];
        end
    end

    assign top_bits  = top_reg;
    assign bit_total = tot_reg;
    assign status    = sts_reg;

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAP_BITS)) else $error("fill above capacity");
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !finish |=> $stable(fill_reg)) else $error("fill moved outside finish");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !$past(ov_reg && out_stall)) else $error("start while result blocked");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(top_bits)) else $error("result lost");
endmodule

[design/variable_width_bit_stack_unit.sv]
// Top level of the variable-width bit stack.
// A transaction passes the command queue, then back-end states RD0, RD1 and EX (and WR for a
// push spanning two words) before its result is registered; the back end takes a new command
// only from idle, and a stalled result holds off the next command.
// The single-port word memory is read twice per item and written once or twice per successful nonzero push.
// Reset clears the bit count, queue and result valid; memory contents are left undefined.
module variable_width_bit_stack_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] value,
    input  logic [5:0]  count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] top_bits,
    output logic [11:0] bit_total,
    output logic [1:0]  status
);
    import vwbs_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take;

    vwbs_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .op(op), .value(value), .count(count),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
    );

    vwbs_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall),
        .top_bits(top_bits), .bit_total(bit_total), .status(status)
    );
endmodule
